@@ rtl/odf_pkg.sv @@
`default_nettype none

package odf_pkg;

	// Lacing store geometry
	localparam int LACE_DEPTH = 256;
	localparam int LACE_AW    = $clog2(LACE_DEPTH);

	// Page header layout (byte offsets from the capture pattern)
	localparam int HDR_FIXED    = 27;
	localparam int HEADER_LIMIT = 282;
	localparam int HB_FLAGS     = 5;
	localparam int HB_GRAN_LO   = 6;
	localparam int HB_GRAN_HI   = 13;
	localparam int HB_SER_LO    = 14;
	localparam int HB_SER_HI    = 17;
	localparam int HB_SEGS      = 26;
	localparam int HB_FIRST     = 4;

	localparam logic [7:0] LACE_FULL = 8'd255;

	// Capture pattern
	localparam logic [7:0] CAP_O = 8'h4F;
	localparam logic [7:0] CAP_G = 8'h67;
	localparam logic [7:0] CAP_S = 8'h53;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_BODY   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_BODY   = 2'd1;
	localparam logic [1:0] ERR_HEADER = 2'd2;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_LACING,
		PH_BODY
	} phase_t;

	// One compacted lacing entry: a nonzero segment and whether it ends a packet
	typedef struct packed {
		logic       last;
		logic [7:0] len;
	} lace_ent_t;

	typedef struct packed {
		logic               we;
		logic [LACE_AW-1:0] waddr;
		lace_ent_t          wdata;
		logic               re;
		logic [LACE_AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        begin_of_stream;
		logic        end_of_stream;
		logic        continued_packet;
		logic [31:0] serial_number;
		logic [63:0] granule_position;
		logic [7:0]  segment_count;
		logic [15:0] body_length;
		logic [7:0]  body_data;
		logic        packet_end;
		logic [15:0] packet_length;
		logic [1:0]  error_code;
	} result_t;

	function automatic logic [7:0] capture_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = CAP_O;
			2'd1:    c = CAP_G;
			2'd2:    c = CAP_G;
			2'd3:    c = CAP_S;
			default: c = CAP_O;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/odf_lacing_mem.sv @@
`default_nettype none

module odf_lacing_mem (
	input  wire logic              clk,
	input  wire odf_pkg::mem_req_t req,
	output odf_pkg::lace_ent_t     rdata
);
	import odf_pkg::*;

	lace_ent_t mem_q [LACE_DEPTH];
	lace_ent_t rdata_q;

	// Single write port, registered read; write-first on an address clash
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			if (req.we && (req.waddr == req.raddr)) begin
				rdata_q <= req.wdata;
			end else begin
				rdata_q <= mem_q[req.raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/odf_parser.sv @@
`default_nettype none

module odf_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [7:0]         byte_in,
	input  wire logic [16:0]        body_limit,
	input  wire odf_pkg::lace_ent_t rdata,
	output odf_pkg::mem_req_t       mreq,
	output logic                    res_fire,
	output odf_pkg::result_t        res
);
	import odf_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  sync_q, sync_d;
	logic [4:0]  hidx_q, hidx_d;
	logic [2:0]  flags_q, flags_d;
	logic [63:0] gran_q, gran_d;
	logic [31:0] serial_q, serial_d;
	logic [7:0]  segs_q, segs_d;
	logic [7:0]  raw_cnt_q, raw_cnt_d;
	logic [16:0] sum_q, sum_d;
	logic [7:0]  ncnt_q, ncnt_d;
	logic        lead0_q, lead0_d;
	logic        prev255_q, prev255_d;
	lace_ent_t   first_q, first_d;
	logic [7:0]  cur_left_q, cur_left_d;
	logic        cur_last_q, cur_last_d;
	logic [7:0]  nidx_q, nidx_d;
	logic [15:0] rpl_q, rpl_d;

	// Table completion inputs
	logic        fin;
	logic [16:0] sum_f;
	logic [7:0]  segs_f;
	logic [7:0]  ncnt_f;
	lace_ent_t   first_f;
	logic        lead0_f;

	logic [2:0]  gsel;
	logic [1:0]  ssel;
	logic [15:0] len_inc;
	logic        seg_done;
	logic        pkt_end;
	lace_ent_t   new_ent;

	assign gsel    = 3'(hidx_q - 5'(HB_GRAN_LO));
	assign ssel    = 2'(hidx_q - 5'(HB_SER_LO));
	assign len_inc = (rpl_q == 16'hFFFF) ? rpl_q : rpl_q + 16'd1;

	// Next state and result
	always_comb begin
		phase_d    = phase_q;
		sync_d     = sync_q;
		hidx_d     = hidx_q;
		flags_d    = flags_q;
		gran_d     = gran_q;
		serial_d   = serial_q;
		segs_d     = segs_q;
		raw_cnt_d  = raw_cnt_q;
		sum_d      = sum_q;
		ncnt_d     = ncnt_q;
		lead0_d    = lead0_q;
		prev255_d  = prev255_q;
		first_d    = first_q;
		cur_left_d = cur_left_q;
		cur_last_d = cur_last_q;
		nidx_d     = nidx_q;
		rpl_d      = rpl_q;
		mreq       = '0;
		res        = '0;
		res_fire   = 1'b0;
		fin        = 1'b0;
		sum_f      = sum_q;
		segs_f     = segs_q;
		ncnt_f     = ncnt_q;
		first_f    = first_q;
		lead0_f    = lead0_q;
		seg_done   = 1'b0;
		pkt_end    = 1'b0;
		new_ent    = '0;

		if (take) begin
			case (phase_q)
				PH_HUNT: begin
					// Capture pattern match, restarting at one on a stray 'O'
					if (byte_in == capture_char(sync_q)) begin
						if (sync_q == 2'd3) begin
							phase_d = PH_HEADER;
							hidx_d  = 5'(HB_FIRST);
							sync_d  = 2'd0;
						end else begin
							sync_d = sync_q + 2'd1;
						end
					end else begin
						sync_d = (byte_in == CAP_O) ? 2'd1 : 2'd0;
					end
				end

				PH_HEADER: begin
					if (hidx_q == 5'(HB_FLAGS)) begin
						flags_d = byte_in[2:0];
					end else if (hidx_q inside {[HB_GRAN_LO:HB_GRAN_HI]}) begin
						gran_d[8*gsel +: 8] = byte_in;
					end else if (hidx_q inside {[HB_SER_LO:HB_SER_HI]}) begin
						serial_d[8*ssel +: 8] = byte_in;
					end
					if (hidx_q == 5'(HB_SEGS)) begin
						segs_d    = byte_in;
						raw_cnt_d = '0;
						sum_d     = '0;
						ncnt_d    = '0;
						lead0_d   = 1'b0;
						prev255_d = 1'b0;
						if (byte_in == 8'd0) begin
							fin     = 1'b1;
							sum_f   = '0;
							segs_f  = byte_in;
							ncnt_f  = '0;
							first_f = first_q;
							lead0_f = 1'b0;
						end else begin
							phase_d = PH_LACING;
						end
					end else begin
						hidx_d = hidx_q + 5'd1;
					end
				end

				PH_LACING: begin
					// Compact nonzero segments; a zero after 255 marks that entry's end
					sum_d     = sum_q + 17'(byte_in);
					raw_cnt_d = raw_cnt_q + 8'd1;
					prev255_d = (byte_in == LACE_FULL);
					if (byte_in != 8'd0) begin
						new_ent.len  = byte_in;
						new_ent.last = (byte_in != LACE_FULL);
						mreq.we      = 1'b1;
						mreq.waddr   = ncnt_q;
						mreq.wdata   = new_ent;
						ncnt_d       = ncnt_q + 8'd1;
						if (ncnt_q == 8'd0) begin
							first_d = new_ent;
						end
					end else if (prev255_q) begin
						new_ent.len  = LACE_FULL;
						new_ent.last = 1'b1;
						mreq.we      = 1'b1;
						mreq.waddr   = ncnt_q - 8'd1;
						mreq.wdata   = new_ent;
						if (ncnt_q == 8'd1) begin
							first_d = new_ent;
						end
					end else if (ncnt_q == 8'd0) begin
						lead0_d = 1'b1;
					end
					if (({1'b0, raw_cnt_q} + 9'd1) >= {1'b0, segs_q}) begin
						fin     = 1'b1;
						sum_f   = sum_d;
						segs_f  = segs_q;
						ncnt_f  = ncnt_d;
						first_f = first_d;
						lead0_f = lead0_d;
					end
				end

				PH_BODY: begin
					// Body byte: walk the current segment, prefetch the next entry
					if (cur_left_q <= 8'd1) begin
						seg_done = 1'b1;
						pkt_end  = cur_last_q;
					end else begin
						cur_left_d = cur_left_q - 8'd1;
					end
					res_fire          = 1'b1;
					res.kind          = KIND_BODY;
					res.body_data     = byte_in;
					res.packet_end    = pkt_end;
					res.packet_length = pkt_end ? len_inc : 16'd0;
					rpl_d             = pkt_end ? 16'd0 : len_inc;
					if (seg_done) begin
						if (nidx_q < ncnt_q) begin
							cur_left_d = rdata.len;
							cur_last_d = rdata.last;
							mreq.re    = 1'b1;
							mreq.raddr = nidx_q + 8'd1;
							nidx_d     = nidx_q + 8'd1;
						end else begin
							phase_d = PH_HUNT;
							sync_d  = 2'd0;
							hidx_d  = '0;
						end
					end
				end

				default: begin
					phase_d = PH_HUNT;
				end
			endcase

			// Segment table complete: check limits, then emit header summary
			if (fin) begin
				res_fire = 1'b1;
				sync_d   = 2'd0;
				hidx_d   = '0;
				if (sum_f >= body_limit) begin
					res.kind       = KIND_ERROR;
					res.error_code = ERR_BODY;
					rpl_d          = '0;
					phase_d        = PH_HUNT;
				end else if (({1'b0, segs_f} + 9'(HDR_FIXED)) > 9'(HEADER_LIMIT)) begin
					res.kind       = KIND_ERROR;
					res.error_code = ERR_HEADER;
					rpl_d          = '0;
					phase_d        = PH_HUNT;
				end else begin
					res.kind             = KIND_HEADER;
					res.begin_of_stream  = flags_q[1];
					res.end_of_stream    = flags_q[2];
					res.continued_packet = flags_q[0];
					res.serial_number    = serial_q;
					res.granule_position = gran_q;
					res.segment_count    = segs_f;
					res.body_length      = sum_f[15:0];
					if (!flags_q[0] || lead0_f) begin
						rpl_d = '0;
					end
					if (ncnt_f == 8'd0) begin
						phase_d = PH_HUNT;
					end else begin
						phase_d    = PH_BODY;
						cur_left_d = first_f.len;
						cur_last_d = first_f.last;
						mreq.re    = 1'b1;
						mreq.raddr = 8'd1;
						nidx_d     = 8'd1;
					end
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			sync_q     <= '0;
			hidx_q     <= '0;
			flags_q    <= '0;
			gran_q     <= '0;
			serial_q   <= '0;
			segs_q     <= '0;
			raw_cnt_q  <= '0;
			sum_q      <= '0;
			ncnt_q     <= '0;
			lead0_q    <= 1'b0;
			prev255_q  <= 1'b0;
			cur_left_q <= '0;
			cur_last_q <= 1'b0;
			nidx_q     <= '0;
			rpl_q      <= '0;
		end else begin
			phase_q    <= phase_d;
			sync_q     <= sync_d;
			hidx_q     <= hidx_d;
			flags_q    <= flags_d;
			gran_q     <= gran_d;
			serial_q   <= serial_d;
			segs_q     <= segs_d;
			raw_cnt_q  <= raw_cnt_d;
			sum_q      <= sum_d;
			ncnt_q     <= ncnt_d;
			lead0_q    <= lead0_d;
			prev255_q  <= prev255_d;
			cur_left_q <= cur_left_d;
			cur_last_q <= cur_last_d;
			nidx_q     <= nidx_d;
			rpl_q      <= rpl_d;
		end
	end

	// First entry kept beside the memory so the body can start at once
	always_ff @(posedge clk) begin
		first_q <= first_d;
	end

endmodule

`default_nettype wire

@@ rtl/ogg_page_deframer_core.sv @@
`default_nettype none

// Ogg page deframer. Takes one stream byte per item, hunts for the "OggS"
// capture pattern, collects the 27-byte page header and the segment table,
// then gives one page header summary (or an error item when the body reaches
// body_limit or the header is too long), followed by one item per body byte
// with packet-end marks and packet lengths carried across pages. A byte that
// causes no item simply vanishes. Throughput is one byte per clock, sustained,
// in every phase unless stalled; the result leaves through an output register
// in the cycle after the byte is taken. Nonzero lacing values are compacted
// into a 256-entry memory with one write port and a registered read port;
// the segment walk prefetches the next entry, which holds the body at one
// byte per clock when not stalled, even with one-byte segments. No clearing
// pass follows reset. stream_stall rises only while a held result is stalled.

module ogg_page_deframer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Stream byte channel
	input  wire logic        stream_valid,
	output logic             stream_stall,
	input  wire logic [7:0]  stream_byte,
	// Result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic             begin_of_stream,
	output logic             end_of_stream,
	output logic             continued_packet,
	output logic [31:0]      serial_number,
	output logic [63:0]      granule_position,
	output logic [7:0]       segment_count,
	output logic [15:0]      body_length,
	output logic [7:0]       body_data,
	output logic             packet_end,
	output logic [15:0]      packet_length,
	output logic [1:0]       error_code,
	// Configuration
	input  wire logic        cfg_write_en,
	input  wire logic [16:0] cfg_write_data
);
	import odf_pkg::*;

	logic        take;
	logic        res_fire;
	result_t     res;
	result_t     res_q;
	logic        res_valid_q;
	logic [16:0] body_limit_q;
	mem_req_t    mreq;
	lace_ent_t   rdata;

	// Accept while the output register is empty or draining
	assign stream_stall = res_valid_q && result_stall;
	assign take         = stream_valid && !stream_stall;

	// Body limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limit_q <= 17'h10000;
		end else if (cfg_write_en) begin
			body_limit_q <= cfg_write_data;
		end
	end

	odf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_in    (stream_byte),
		.body_limit (body_limit_q),
		.rdata      (rdata),
		.mreq       (mreq),
		.res_fire   (res_fire),
		.res        (res)
	);

	odf_lacing_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && res_fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (take && res_fire) begin
			res_q <= res;
		end
	end

	assign result_valid     = res_valid_q;
	assign kind             = res_q.kind;
	assign begin_of_stream  = res_q.begin_of_stream;
	assign end_of_stream    = res_q.end_of_stream;
	assign continued_packet = res_q.continued_packet;
	assign serial_number    = res_q.serial_number;
	assign granule_position = res_q.granule_position;
	assign segment_count    = res_q.segment_count;
	assign body_length      = res_q.body_length;
	assign body_data        = res_q.body_data;
	assign packet_end       = res_q.packet_end;
	assign packet_length    = res_q.packet_length;
	assign error_code       = res_q.error_code;

endmodule

`default_nettype wire

@@ verif/ogg_page_deframer_core_tb.sv @@
`timescale 1ns / 100ps

module ogg_page_deframer_core_tb;
	import odf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        stream_valid = 1'b0;
	logic        stream_stall;
	logic [7:0]  stream_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic        begin_of_stream;
	logic        end_of_stream;
	logic        continued_packet;
	logic [31:0] serial_number;
	logic [63:0] granule_position;
	logic [7:0]  segment_count;
	logic [15:0] body_length;
	logic [7:0]  body_data;
	logic        packet_end;
	logic [15:0] packet_length;
	logic [1:0]  error_code;
	logic        cfg_write_en = 1'b0;
	logic [16:0] cfg_write_data = 17'd0;

	ogg_page_deframer_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.stream_valid     (stream_valid),
		.stream_stall     (stream_stall),
		.stream_byte      (stream_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.kind             (kind),
		.begin_of_stream  (begin_of_stream),
		.end_of_stream    (end_of_stream),
		.continued_packet (continued_packet),
		.serial_number    (serial_number),
		.granule_position (granule_position),
		.segment_count    (segment_count),
		.body_length      (body_length),
		.body_data        (body_data),
		.packet_end       (packet_end),
		.packet_length    (packet_length),
		.error_code       (error_code),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data)
	);

	// Shared run state
	result_t    expected_results [$];
	logic [7:0] lacing_plan [$];
	int         cycle_count = 0;
	int         mismatch_count = 0;
	int         bytes_sent = 0;
	int         results_seen = 0;
	int         headers_seen = 0;
	int         errors_seen = 0;
	int         packet_ends_seen = 0;
	int         limit_writes = 0;
	int         hold_request = 0;
	bit         sender_gaps = 1'b1;
	bit         receiver_gaps = 1'b1;

	// Deframer prediction state
	phase_t      pr_phase = PH_HUNT;
	logic [1:0]  pr_sync = 2'd0;
	logic [4:0]  pr_hdr_idx = 5'd0;
	logic [2:0]  pr_flags = 3'd0;
	logic [63:0] pr_granule = 64'd0;
	logic [31:0] pr_serial = 32'd0;
	logic [7:0]  pr_seg_total = 8'd0;
	logic [7:0]  pr_lace [LACE_DEPTH];
	int          pr_seg_ptr = 0;
	logic [16:0] pr_body_sum = 17'd0;
	int          pr_seg_left = 0;
	int          pr_run_len = 0;
	logic [16:0] pr_limit = 17'd65536;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic void restart_hunt();
		pr_phase   = PH_HUNT;
		pr_sync    = 2'd0;
		pr_hdr_idx = 5'd0;
	endfunction

	// First nonzero segment at or after start; skipped zero segments close the packet
	function automatic bit next_segment(input int start);
		for (int i = start; i < pr_seg_total; i++) begin
			if (pr_lace[i] != 8'd0) begin
				pr_seg_ptr  = i;
				pr_seg_left = pr_lace[i];
				return 1'b1;
			end
			pr_run_len = 0;
		end
		return 1'b0;
	endfunction

	// Segment table complete: header summary or error
	function automatic void close_page_table();
		result_t r;
		r = '0;
		if (pr_body_sum >= pr_limit) begin
			r.kind       = KIND_ERROR;
			r.error_code = ERR_BODY;
			pr_run_len   = 0;
			restart_hunt();
		end else if (HDR_FIXED + int'(pr_seg_total) > HEADER_LIMIT) begin
			r.kind       = KIND_ERROR;
			r.error_code = ERR_HEADER;
			pr_run_len   = 0;
			restart_hunt();
		end else begin
			r.kind             = KIND_HEADER;
			r.begin_of_stream  = pr_flags[1];
			r.end_of_stream    = pr_flags[2];
			r.continued_packet = pr_flags[0];
			r.serial_number    = pr_serial;
			r.granule_position = pr_granule;
			r.segment_count    = pr_seg_total;
			r.body_length      = pr_body_sum[15:0];
			if (!pr_flags[0])
				pr_run_len = 0;
			if (next_segment(0))
				pr_phase = PH_BODY;
			else
				restart_hunt();
		end
		expected_results.push_back(r);
	endfunction

	// Advance the prediction by one accepted stream byte
	function automatic void deframe_byte(input logic [7:0] b);
		logic [7:0] capture [4];
		result_t    r;
		int         k;
		int         len;
		int         p;
		bit         ends;
		capture = '{CAP_O, CAP_G, CAP_G, CAP_S};
		case (pr_phase)
			PH_HUNT: begin
				if (b == capture[pr_sync]) begin
					if (pr_sync == 2'd3) begin
						pr_phase   = PH_HEADER;
						pr_hdr_idx = 5'(HB_FIRST);
						pr_sync    = 2'd0;
					end else begin
						pr_sync++;
					end
				end else begin
					pr_sync = (b == CAP_O) ? 2'd1 : 2'd0;
				end
			end
			PH_HEADER: begin
				k = pr_hdr_idx;
				if (k == HB_FLAGS) begin
					pr_flags = b[2:0];
				end else if (k >= HB_GRAN_LO && k <= HB_GRAN_HI) begin
					pr_granule[(k - HB_GRAN_LO) * 8 +: 8] = b;
				end else if (k >= HB_SER_LO && k <= HB_SER_HI) begin
					pr_serial[(k - HB_SER_LO) * 8 +: 8] = b;
				end else if (k == HB_SEGS) begin
					pr_seg_total = b;
					pr_seg_ptr   = 0;
					pr_body_sum  = 17'd0;
					pr_seg_left  = 0;
					if (b == 8'd0)
						close_page_table();
					else
						pr_phase = PH_LACING;
					return;
				end
				pr_hdr_idx = 5'(k + 1);
			end
			PH_LACING: begin
				pr_lace[pr_seg_ptr] = b;
				pr_body_sum = pr_body_sum + 17'(b);
				pr_seg_ptr++;
				if (pr_seg_ptr >= pr_seg_total)
					close_page_table();
			end
			default: begin
				len = (pr_run_len < 65535) ? pr_run_len + 1 : 65535;
				p = pr_seg_ptr;
				pr_run_len = len;
				ends = 1'b0;
				if (pr_seg_left <= 1) begin
					if (pr_lace[p] < LACE_FULL)
						ends = 1'b1;
					else if (p + 1 < pr_seg_total && pr_lace[p + 1] == 8'd0)
						ends = 1'b1;
					pr_seg_left = 0;
				end else begin
					pr_seg_left--;
				end
				r = '0;
				r.kind          = KIND_BODY;
				r.body_data     = b;
				r.packet_end    = ends;
				r.packet_length = ends ? 16'(len) : 16'd0;
				expected_results.push_back(r);
				if (ends)
					pr_run_len = 0;
				if (pr_seg_left == 0 && !next_segment(p + 1))
					restart_hunt();
			end
		endcase
	endfunction

	// Receiver: random stalls, or a long hold-off when asked for
	initial begin : receiver_side
		int run;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				run = hold_request;
				hold_request = 0;
			end else if (run == 0 && receiver_gaps && $urandom_range(0, 3) == 0) begin
				run = pick_gap();
			end
			if (run > 0) begin
				result_stall = 1'b1;
				run--;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{kind, begin_of_stream, end_of_stream, continued_packet, serial_number,
				granule_position, segment_count, body_length, body_data, packet_end,
				packet_length, error_code};
			results_seen++;
			if (got.kind == KIND_HEADER)
				headers_seen++;
			if (got.kind == KIND_ERROR)
				errors_seen++;
			if (got.kind == KIND_BODY && got.packet_end)
				packet_ends_seen++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: kind %0d data %h at cycle %0d",
						got.kind, got.body_data, cycle_count);
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind || got.begin_of_stream !== want.begin_of_stream
						|| got.end_of_stream !== want.end_of_stream
						|| got.continued_packet !== want.continued_packet
						|| got.serial_number !== want.serial_number
						|| got.granule_position !== want.granule_position
						|| got.segment_count !== want.segment_count
						|| got.body_length !== want.body_length
						|| got.body_data !== want.body_data
						|| got.packet_end !== want.packet_end
						|| got.packet_length !== want.packet_length
						|| got.error_code !== want.error_code) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch at cycle %0d (expected/actual): kind %0d/%0d err %0d/%0d",
							cycle_count, want.kind, got.kind, want.error_code, got.error_code);
						$display("  data %h/%h end %b/%b plen %0d/%0d flags %b%b%b/%b%b%b",
							want.body_data, got.body_data, want.packet_end, got.packet_end,
							want.packet_length, got.packet_length, want.end_of_stream,
							want.begin_of_stream, want.continued_packet, got.end_of_stream,
							got.begin_of_stream, got.continued_packet);
						$display("  serial %h/%h granule %h/%h segs %0d/%0d blen %0d/%0d",
							want.serial_number, got.serial_number, want.granule_position,
							got.granule_position, want.segment_count, got.segment_count,
							want.body_length, got.body_length);
					end
				end
			end
		end
	end

	// Offer one stream byte and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			stream_valid = 1'b0;
		end
		@(negedge clk);
		stream_valid = 1'b1;
		stream_byte  = b;
		do
			@(posedge clk);
		while (stream_stall);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// One page built from lacing_plan; cut >= 0 stops after that many bytes
	task automatic send_page(input logic [7:0] flag_byte, input logic [63:0] gran,
			input logic [31:0] ser, input int cut);
		logic [7:0] page [$];
		int body;
		body = 0;
		page = '{CAP_O, CAP_G, CAP_G, CAP_S};
		page.push_back(8'($urandom));
		page.push_back(flag_byte);
		for (int i = 0; i < 8; i++)
			page.push_back(gran[i * 8 +: 8]);
		for (int i = 0; i < 4; i++)
			page.push_back(ser[i * 8 +: 8]);
		// sequence number and CRC, both ignored
		for (int i = 0; i < 8; i++)
			page.push_back(8'($urandom));
		page.push_back(8'(lacing_plan.size()));
		foreach (lacing_plan[i]) begin
			page.push_back(lacing_plan[i]);
			body += lacing_plan[i];
		end
		for (int i = 0; i < body; i++)
			page.push_back(8'($urandom));
		if (cut < 0 || cut > page.size())
			cut = page.size();
		for (int i = 0; i < cut; i++)
			send_byte(page[i]);
	endtask

	// Sender pauses until every expected result is back
	task automatic wait_drained();
		@(negedge clk);
		stream_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_body_limit(input logic [16:0] value);
		wait_drained();
		@(negedge clk);
		cfg_write_en   = 1'b1;
		cfg_write_data = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		pr_limit = value;
		limit_writes++;
	endtask

	// Capture pattern hunting with overlapping false starts, header field extremes
	task automatic test_capture_hunt();
		send_text("OgOggOgg");
		lacing_plan.delete();
		send_page(8'hFF, '1, '1, -1);
		send_text("xOOggOgg");
		lacing_plan = '{8'd1, 8'd1, 8'd1};
		send_page(8'h00, '0, '0, -1);
	endtask

	// Packet-end marks and running packet length across pages
	task automatic test_packet_marks();
		lacing_plan = '{8'd255, 8'd0};
		send_page(8'h02, 64'd100, 32'h1234_5678, -1);
		lacing_plan = '{8'd3, 8'd0, 8'd0, 8'd2};
		send_page(8'h00, 64'd101, 32'h1234_5678, -1);
		lacing_plan = '{8'd0, 8'd0};
		send_page(8'h00, 64'd102, 32'h1234_5678, -1);
		// packet left open, then closed by a leading zero on the continued page
		lacing_plan = '{8'd255};
		send_page(8'h00, 64'd103, 32'h1234_5678, -1);
		lacing_plan = '{8'd0, 8'd4};
		send_page(8'h01, 64'd104, 32'h1234_5678, -1);
		// packet spanning two pages
		lacing_plan = '{8'd255};
		send_page(8'h00, 64'd105, 32'h1234_5678, -1);
		lacing_plan = '{8'd6};
		send_page(8'h01, 64'd106, 32'h1234_5678, -1);
		// fresh page drops the open packet
		lacing_plan = '{8'd255};
		send_page(8'h00, 64'd107, 32'h1234_5678, -1);
		lacing_plan = '{8'd3};
		send_page(8'h04, 64'd108, 32'h1234_5678, -1);
	endtask

	// Body limit errors and their effect on the running packet
	task automatic test_body_limit();
		set_body_limit(17'd100);
		lacing_plan = '{8'd99};
		send_page(8'h00, 64'd1, 32'd1, -1);
		lacing_plan = '{8'd100};
		send_page(8'h00, 64'd2, 32'd1, HDR_FIXED + 1);
		lacing_plan = '{8'd50, 8'd50};
		send_page(8'h00, 64'd3, 32'd1, HDR_FIXED + 2);
		set_body_limit(17'd1);
		lacing_plan = '{8'd0};
		send_page(8'h00, 64'd4, 32'd1, -1);
		lacing_plan = '{8'd1};
		send_page(8'h00, 64'd5, 32'd1, HDR_FIXED + 1);
		set_body_limit(17'd1000);
		lacing_plan = '{8'd255};
		send_page(8'h00, 64'd6, 32'd1, -1);
		lacing_plan = '{8'd255, 8'd255, 8'd255, 8'd255};
		send_page(8'h01, 64'd7, 32'd1, HDR_FIXED + 4);
		lacing_plan = '{8'd5};
		send_page(8'h01, 64'd8, 32'd1, -1);
		set_body_limit(17'd65536);
	endtask

	// Full segment table of zero and one-byte segments, at full rate
	task automatic test_full_table();
		wait_drained();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		lacing_plan.delete();
		repeat (255) lacing_plan.push_back(8'($urandom_range(0, 1)));
		send_page(8'h02, 64'h8000_0000_0000_0001, 32'hA5A5_5A5A, -1);
		wait_drained();
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// Long receiver hold-off so the block backs up into the stream side
	task automatic test_backpressure();
		wait_drained();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		hold_request  = 300;
		lacing_plan = '{8'd40, 8'd20};
		send_page(8'h00, 64'd77, 32'd99, -1);
		wait_drained();
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// Mostly well-formed pages with random content, plus noise and cut pages
	task automatic test_random_stream();
		int start;
		int pages;
		int r;
		int nseg;
		int cut;
		start = bytes_sent;
		pages = 0;
		while (bytes_sent - start < 500) begin
			if (pages % 5 == 0) begin
				sender_gaps   = ($urandom_range(0, 3) != 0);
				receiver_gaps = ($urandom_range(0, 3) != 0);
			end
			if (pages % 6 == 5) begin
				r = $urandom_range(0, 9);
				if (r < 6)
					set_body_limit(17'd65536);
				else if (r < 9)
					set_body_limit(17'($urandom_range(20, 200)));
				else
					set_body_limit(17'($urandom_range(1, 65535)));
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 3))
						0: send_byte(CAP_O);
						1: send_byte(CAP_G);
						2: send_byte(CAP_S);
						default: send_byte(8'($urandom));
					endcase
				end
			end else begin
				lacing_plan.delete();
				nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
				repeat (nseg) begin
					case ($urandom_range(0, 19))
						0, 1, 2: lacing_plan.push_back(8'd0);
						3:       lacing_plan.push_back(LACE_FULL);
						default: lacing_plan.push_back(8'($urandom_range(1, 12)));
					endcase
				end
				cut = (r < 22) ? $urandom_range(1, HDR_FIXED + nseg + 3) : -1;
				send_page(8'($urandom), {$urandom, $urandom}, $urandom, cut);
			end
			pages++;
		end
	endtask

	initial begin : run_tests
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_capture_hunt();
		test_packet_marks();
		test_body_limit();
		test_full_table();
		test_backpressure();
		test_random_stream();
		wait_drained();
		repeat (8) @(posedge clk);
		mismatch_count += expected_results.size();
		$display("stream bytes %0d, results %0d: %0d page headers, %0d errors, %0d packet ends",
			bytes_sent, results_seen, headers_seen, errors_seen, packet_ends_seen);
		$display("body_limit written %0d times, mismatches %0d, cycles %0d",
			limit_writes, mismatch_count, cycle_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/odf_pkg.sv
rtl/odf_lacing_mem.sv
rtl/odf_parser.sv
rtl/ogg_page_deframer_core.sv
verif/ogg_page_deframer_core_tb.sv
